/* src/bdq_pkg.sv */
// Shared types and constants for the bounded deque.
`default_nettype none

package bdq_pkg;

  localparam int DEPTH  = 64;
  localparam int WORD_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W  = 7;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [OCC_W-1:0]         occ_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_DUMP       = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_DUMP
  } state_t;

  // What every cell of the row does in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE,
    CELL_APPEND
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    occ_t     count;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* src/bdq_cell.sv */
// One storage cell of the deque row.
`default_nettype none

module bdq_cell (
  input  wire logic               clk,
  input  wire bdq_pkg::cell_cmd_t cmd,
  input  wire bdq_pkg::idx_t      idx,
  input  wire bdq_pkg::word_t     push_value,
  input  wire bdq_pkg::word_t     prev_word,
  input  wire bdq_pkg::word_t     next_word,
  input  wire bdq_pkg::word_t     head_word,
  output bdq_pkg::word_t          word
);

  bdq_pkg::word_t word_next;
  logic           is_last;
  logic           is_tail;

  assign is_tail = (bdq_pkg::occ_t'(idx) == cmd.count);
  assign is_last = ((bdq_pkg::occ_t'(idx) + bdq_pkg::occ_t'(1)) == cmd.count);

  always_comb begin
    case (cmd.op)
      bdq_pkg::CELL_INSERT: word_next = prev_word;
      bdq_pkg::CELL_REMOVE: word_next = next_word;
      // wrap the head word around to the last occupied cell
      bdq_pkg::CELL_ROTATE: word_next = is_last ? head_word : next_word;
      bdq_pkg::CELL_APPEND: word_next = is_tail ? push_value : word;
      default:              word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

/* src/bdq_ctrl.sv */
// Sequencer for the deque: decodes requests, drives the cell row, holds results.
`default_nettype none

module bdq_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [bdq_pkg::OP_W-1:0] op,
  input  wire bdq_pkg::word_t           head_word,
  output bdq_pkg::cell_cmd_t            cmd,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output bdq_pkg::word_t                out_value,
  output logic [bdq_pkg::STAT_W-1:0]    status,
  output bdq_pkg::occ_t                 occupancy,
  output logic                          last
);

  bdq_pkg::state_t  state, state_next;
  bdq_pkg::occ_t    count, count_next;
  bdq_pkg::idx_t    step, step_next;
  bdq_pkg::cell_op_t cell_op;

  logic             can_emit;
  logic             accept;
  logic             emit;
  bdq_pkg::word_t   e_value;
  bdq_pkg::status_t e_status;
  logic             e_last;
  logic             step_at_end;

  assign can_emit    = !out_valid || !out_stall;
  assign in_stall    = (state != bdq_pkg::S_IDLE) || !can_emit;
  assign accept      = in_valid && !in_stall;
  assign step_at_end = (bdq_pkg::occ_t'(step) == (count - bdq_pkg::occ_t'(1)));

  assign cmd.op    = cell_op;
  assign cmd.count = count;

  always_comb begin
    state_next = state;
    count_next = count;
    step_next  = step;
    cell_op    = bdq_pkg::CELL_HOLD;
    emit       = 1'b0;
    e_value    = '0;
    e_status   = bdq_pkg::STAT_OK;
    e_last     = 1'b1;
    case (state)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          case (bdq_pkg::op_t'(op))
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_REAR: begin
              emit = 1'b1;
              if (count == bdq_pkg::occ_t'(bdq_pkg::DEPTH)) begin
                e_status = bdq_pkg::STAT_FULL;
              end else begin
                cell_op    = (bdq_pkg::op_t'(op) == bdq_pkg::OP_PUSH_FRONT) ?
                             bdq_pkg::CELL_INSERT : bdq_pkg::CELL_APPEND;
                count_next = count + bdq_pkg::occ_t'(1);
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              emit = 1'b1;
              if (count == '0) begin
                e_status = bdq_pkg::STAT_EMPTY;
              end else begin
                e_value    = head_word;
                cell_op    = bdq_pkg::CELL_REMOVE;
                count_next = count - bdq_pkg::occ_t'(1);
              end
            end
            bdq_pkg::OP_POP_REAR: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = bdq_pkg::STAT_EMPTY;
              end else if (count == bdq_pkg::occ_t'(1)) begin
                emit       = 1'b1;
                e_value    = head_word;
                cell_op    = bdq_pkg::CELL_REMOVE;
                count_next = '0;
              end else begin
                state_next = bdq_pkg::S_ROT;
                step_next  = '0;
              end
            end
            bdq_pkg::OP_DUMP: begin
              if (count == '0) begin
                emit     = 1'b1;
                e_status = bdq_pkg::STAT_EMPTY;
              end else begin
                state_next = bdq_pkg::S_DUMP;
                step_next  = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bdq_pkg::S_ROT: begin
        // rotate until the rear word sits in the head cell, then pop it
        if (step_at_end) begin
          if (can_emit) begin
            emit       = 1'b1;
            e_value    = head_word;
            cell_op    = bdq_pkg::CELL_REMOVE;
            count_next = count - bdq_pkg::occ_t'(1);
            state_next = bdq_pkg::S_IDLE;
          end
        end else begin
          cell_op   = bdq_pkg::CELL_ROTATE;
          step_next = step + bdq_pkg::idx_t'(1);
        end
      end
      bdq_pkg::S_DUMP: begin
        // emit the head and rotate; a full turn restores the order
        if (can_emit) begin
          emit      = 1'b1;
          e_value   = head_word;
          e_last    = step_at_end;
          cell_op   = bdq_pkg::CELL_ROTATE;
          step_next = step + bdq_pkg::idx_t'(1);
          if (step_at_end) begin
            state_next = bdq_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = bdq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bdq_pkg::S_IDLE;
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value <= e_value;
      status    <= e_status;
      occupancy <= count_next;
      last      <= e_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bdq_pkg::occ_t'(bdq_pkg::DEPTH))
    else $error("stored count above depth");

  a_rot_needs_two: assert property (@(posedge clk) disable iff (rst)
    state == bdq_pkg::S_ROT |-> count >= bdq_pkg::occ_t'(2))
    else $error("rear rotation with fewer than two words");

  a_dump_step: assert property (@(posedge clk) disable iff (rst)
    state == bdq_pkg::S_DUMP |-> bdq_pkg::occ_t'(step) < count)
    else $error("dump step past the stored words");

  a_no_emit_when_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !emit)
    else $error("result produced over a stalled one");

  a_count_moves_by_one: assert property (@(posedge clk) disable iff (rst)
    count != count_next |-> emit && (cell_op == bdq_pkg::CELL_INSERT ||
      cell_op == bdq_pkg::CELL_APPEND || cell_op == bdq_pkg::CELL_REMOVE))
    else $error("count changed without a push or pop");

endmodule

`default_nettype wire

/* src/bounded_deque.sv */
// Top level of the bounded deque: sequencer plus a row of storage cells.
//
// A bounded double-ended queue of signed 32-bit words, DEPTH entries deep.
// Input request (in_valid/in_stall): op and push_value. Result channel
// (out_valid/out_stall): out_value, status, occupancy, last. A request or
// result is taken at a rising edge where valid is high and stall is low.
// The words sit in a row of cells, front word in cell 0. Push front shifts
// the row toward the rear, pop front shifts it toward the front, push rear
// writes the first free cell. A rotation moves every occupied cell one
// place toward the front and wraps cell 0 to the last occupied cell.
// Push, pop front and pop rear of a single word: requests are taken back to
// back while the result channel does not stall, result in the cycle after accept.
// Pop rear with N >= 2 words: an accept step, N-1 rotations, then the pop,
// which gives the result; no new request is taken until it is done.
// Dump with N words: an accept step, then one word per cycle while the result
// channel does not stall, N words in all, rotating the row so that it ends in
// its original order; last marks the final word. Bad op codes are dropped with no result.
// Reset clears the count and the sequencer; cell contents are not cleared.
// While out_stall holds a result, in_stall stays high; a rear pop keeps
// rotating and waits only at its final pop, a dump holds in place.
`default_nettype none

module bounded_deque (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [bdq_pkg::OP_W-1:0]     op,
  input  wire logic signed [bdq_pkg::WORD_W-1:0] push_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [bdq_pkg::WORD_W-1:0] out_value,
  output logic [bdq_pkg::STAT_W-1:0]        status,
  output logic [bdq_pkg::OCC_W-1:0]         occupancy,
  output logic                              last
);

  bdq_pkg::cell_cmd_t cmd;
  bdq_pkg::word_t     words [bdq_pkg::DEPTH];

  // sequencer: request decode, counts, result register
  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .head_word (words[0]),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .status    (status),
    .occupancy (occupancy),
    .last      (last)
  );

  // row of cells: each sees its neighbors and the head cell
  for (genvar gi = 0; gi < bdq_pkg::DEPTH; gi++) begin : g_cell
    bdq_pkg::word_t prev_w;
    bdq_pkg::word_t next_w;

    if (gi == 0) begin : g_first
      assign prev_w = push_value;
    end else begin : g_mid
      assign prev_w = words[gi-1];
    end

    if (gi == bdq_pkg::DEPTH - 1) begin : g_end
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = words[gi+1];
    end

    bdq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (bdq_pkg::idx_t'(gi)),
      .push_value (push_value),
      .prev_word  (prev_w),
      .next_word  (next_w),
      .head_word  (words[0]),
      .word       (words[gi])
    );
  end

endmodule

`default_nettype wire
